@@ src/linear_svm_classifier_assert.svh @@
// Assertion macros shared by the linear SVM classifier RTL.
`ifndef LINEAR_SVM_CLASSIFIER_ASSERT_SVH
`define LINEAR_SVM_CLASSIFIER_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define LSVM_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define LSVM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define LSVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/lsvm_pkg.sv @@
// Shared types, constants and saturating arithmetic for the linear SVM classifier.
`timescale 1ns / 1ps

package lsvm_pkg;

  // Field widths of the input and result transactions.
  localparam int OPCODE_W = 3;
  localparam int CLASS_W  = 4;
  localparam int FEAT_W   = 10;
  localparam int VALUE_W  = 32;
  localparam int SCORE_W  = 64;

  // Operand width of the shared multiplier: a Q16.16 difference needs one extra bit.
  localparam int MUL_IN_W = VALUE_W + 1;

  // Number of active classes after reset.
  localparam logic [CLASS_W-1:0] ACTIVE_RESET = 4'd10;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // Operation codes carried in the opcode field.
  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD_WEIGHT    = 3'd0,
    OP_LOAD_MEAN      = 3'd1,
    OP_LOAD_RECIP     = 3'd2,
    OP_LOAD_INTERCEPT = 3'd3,
    OP_SAMPLE         = 3'd4
  } opcode_t;

  // Signed 64-bit addition that clips to the representable range.
  function automatic logic signed [SCORE_W-1:0] sat_add(
    input logic signed [SCORE_W-1:0] a,
    input logic signed [SCORE_W-1:0] b
  );
    logic [SCORE_W:0] s;
    s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
    if (s[SCORE_W] != s[SCORE_W-1]) begin
      return s[SCORE_W] ? SCORE_MIN : SCORE_MAX;
    end
    return s[SCORE_W-1:0];
  endfunction

endpackage

@@ src/lsvm_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps

module lsvm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data is registered and valid in the cycle after the address.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/lsvm_mul.sv @@
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module lsvm_mul (
  input  logic                                 clk,
  input  logic signed [lsvm_pkg::MUL_IN_W-1:0] a,
  input  logic signed [lsvm_pkg::MUL_IN_W-1:0] b,
  output logic signed [lsvm_pkg::SCORE_W-1:0]  p
);

  logic signed [2*lsvm_pkg::MUL_IN_W-1:0] full;

  // Full-width product; every operand pair used here fits in 64 bits.
  assign full = a * b;

  always_ff @(posedge clk) begin
    p <= full[lsvm_pkg::SCORE_W-1:0];
  end

endmodule

@@ src/linear_svm_classifier.sv @@
// Linear one-vs-rest SVM classifier: sequencer, tables and result register.
`timescale 1ns / 1ps
`include "linear_svm_classifier_assert.svh"

// Linear one-vs-rest SVM inference in fixed point. Load transactions (opcodes 0 to 3) write the
// weight, mean, reciprocal-scale and intercept tables. A feature sample (opcode 4) is
// standardised as (x - mean) * recip_scale, rounded to Q16.16, and multiplied into every class
// accumulator; the one shared multiplier serves the normalisation and then one class per cycle,
// followed by the pipeline drain. The sample marked tlast then scores the active classes
// against their intercepts, one class per cycle, and presents the best class and its saturated
// Q32.32 score on the master side; on ties the lowest class wins. A tlast sample that arrives
// after the feature count is reached goes straight to scoring. A finished result waits in the
// output register while the next load or sample is taken; a new result holds the block until
// the previous one has been taken. The block is not ready while it works.
module linear_svm_classifier #(
  parameter int FEATURE_COUNT = 1024,
  parameter int CLASS_COUNT   = 10
) (
  input  logic        clk,
  input  logic        rst,
  // Fields from bit 0: opcode[2:0], class_index[6:3], feature_index[16:7], value[48:17].
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: predicted_class[3:0], best_score[67:4].
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);

  localparam int FW  = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int PW  = $clog2(FEATURE_COUNT + 1);
  localparam int CIW = $clog2(CLASS_COUNT);
  localparam int CW  = $clog2(CLASS_COUNT + 1);
  localparam int WAW = $clog2(CLASS_COUNT * FEATURE_COUNT);
  localparam int VW  = lsvm_pkg::VALUE_W;
  localparam int SW  = lsvm_pkg::SCORE_W;
  localparam int MW  = lsvm_pkg::MUL_IN_W;

  localparam logic [PW-1:0]  POS_MAX    = PW'(FEATURE_COUNT);
  localparam logic [CIW-1:0] CLASS_LAST = CIW'(CLASS_COUNT - 1);
  localparam logic [WAW-1:0] ROW_STEP   = WAW'(FEATURE_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM_MUL,
    S_NORM_SAT,
    S_ACC,
    S_DRAIN,
    S_SCORE,
    S_RESULT
  } state_t;

  state_t state;

  // Input field decode.
  logic [lsvm_pkg::OPCODE_W-1:0] op_in;
  logic [lsvm_pkg::CLASS_W-1:0]  cls_in;
  logic [lsvm_pkg::FEAT_W-1:0]   feat_in;
  logic [VW-1:0]                 val_in;
  logic                          accept;
  logic                          cls_ok;
  logic                          feat_ok;

  assign op_in   = s_axis_tdata[2:0];
  assign cls_in  = s_axis_tdata[6:3];
  assign feat_in = s_axis_tdata[16:7];
  assign val_in  = s_axis_tdata[48:17];
  assign s_axis_tready = (state == S_IDLE);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign cls_ok  = 32'(cls_in) < CLASS_COUNT;
  assign feat_ok = 32'(feat_in) < FEATURE_COUNT;

  // Sequencer registers.
  logic [PW-1:0]               pos;
  logic signed [VW-1:0]        s_val;
  logic                        s_last;
  logic signed [VW-1:0]        norm;
  logic [WAW-1:0]              waddr;
  logic [CIW-1:0]              ci;
  logic [lsvm_pkg::CLASS_W-1:0] active_cfg;
  logic [CLASS_COUNT-1:0]      acc_valid;

  // Accumulate pipeline and scoring stage.
  logic                        v1;
  logic                        v2;
  logic [CIW-1:0]              tag1;
  logic [CIW-1:0]              tag2;
  logic signed [SW-1:0]        acc2;
  logic                        sv1;
  logic [CIW-1:0]              stag1;
  logic signed [SW-1:0]        best;
  logic [CIW-1:0]              best_idx;

  // Result register.
  logic                        m_valid;
  logic [lsvm_pkg::CLASS_W-1:0] m_cls;
  logic signed [SW-1:0]        m_score;

  // Memory ports.
  logic [VW-1:0]        mean_rd;
  logic [VW-1:0]        recip_rd;
  logic [VW-1:0]        weight_rd;
  logic [VW-1:0]        icpt_rd;
  logic [SW-1:0]        acc_rd;
  logic                 weight_we;
  logic                 mean_we;
  logic                 recip_we;
  logic                 icpt_we;
  logic                 acc_we;
  logic signed [SW-1:0] acc_wdata;
  logic [WAW-1:0]       weight_waddr;

  // Shared multiplier operands and product.
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [SW-1:0] mul_p;

  // Active class count clipped to one..CLASS_COUNT.
  logic [CW+3:0]  cfg_ext;
  logic [CW-1:0]  n_active;
  logic [CIW-1:0] n_last;

  assign cfg_ext = (CW + 4)'(active_cfg);

  always_comb begin
    if (active_cfg == '0) begin
      n_active = CW'(1);
    end else if (cfg_ext > (CW + 4)'(CLASS_COUNT)) begin
      n_active = CW'(CLASS_COUNT);
    end else begin
      n_active = CW'(active_cfg);
    end
  end

  assign n_last = CIW'(n_active - CW'(1));

  // Round a Q32.32 product to Q16.16 and clip to 32 bits.
  function automatic logic signed [VW-1:0] round_sat(input logic signed [SW-1:0] p);
    logic signed [SW:0] s;
    logic signed [SW:0] sh;
    s  = $signed({p[SW-1], p}) + 65'sd32768;
    sh = s >>> 16;
    if (sh > 65'sd2147483647) begin
      return lsvm_pkg::VALUE_MAX;
    end else if (sh < -65'sd2147483648) begin
      return lsvm_pkg::VALUE_MIN;
    end
    return sh[VW-1:0];
  endfunction

  // Table loads are written straight from the accepted transaction.
  assign weight_we    = accept && (op_in == lsvm_pkg::OP_LOAD_WEIGHT) && cls_ok && feat_ok;
  assign mean_we      = accept && (op_in == lsvm_pkg::OP_LOAD_MEAN) && feat_ok;
  assign recip_we     = accept && (op_in == lsvm_pkg::OP_LOAD_RECIP) && feat_ok;
  assign icpt_we      = accept && (op_in == lsvm_pkg::OP_LOAD_INTERCEPT) && cls_ok;
  assign weight_waddr = WAW'(32'(cls_in) * FEATURE_COUNT + 32'(feat_in));

  lsvm_ram #(.DEPTH(CLASS_COUNT * FEATURE_COUNT), .WIDTH(VW)) u_weight (
    .clk   (clk),
    .we    (weight_we),
    .waddr (weight_waddr),
    .wdata (val_in),
    .raddr (waddr),
    .rdata (weight_rd)
  );

  lsvm_ram #(.DEPTH(FEATURE_COUNT), .WIDTH(VW)) u_mean (
    .clk   (clk),
    .we    (mean_we),
    .waddr (FW'(feat_in)),
    .wdata (val_in),
    .raddr (FW'(pos)),
    .rdata (mean_rd)
  );

  lsvm_ram #(.DEPTH(FEATURE_COUNT), .WIDTH(VW)) u_recip (
    .clk   (clk),
    .we    (recip_we),
    .waddr (FW'(feat_in)),
    .wdata (val_in),
    .raddr (FW'(pos)),
    .rdata (recip_rd)
  );

  lsvm_ram #(.DEPTH(CLASS_COUNT), .WIDTH(VW)) u_icpt (
    .clk   (clk),
    .we    (icpt_we),
    .waddr (CIW'(cls_in)),
    .wdata (val_in),
    .raddr (ci),
    .rdata (icpt_rd)
  );

  // Accumulator write-back from the last pipeline stage.
  assign acc_we    = v2;
  assign acc_wdata = lsvm_pkg::sat_add(acc2, mul_p);

  lsvm_ram #(.DEPTH(CLASS_COUNT), .WIDTH(SW)) u_acc (
    .clk   (clk),
    .we    (acc_we),
    .waddr (tag2),
    .wdata (acc_wdata),
    .raddr (ci),
    .rdata (acc_rd)
  );

  // The multiplier forms weight * norm while classes stream, else (x - mean) * recip.
  always_comb begin
    if (v1) begin
      mul_a = {weight_rd[VW-1], weight_rd};
      mul_b = {norm[VW-1], norm};
    end else begin
      mul_a = $signed({s_val[VW-1], s_val}) - $signed({mean_rd[VW-1], mean_rd});
      mul_b = {recip_rd[VW-1], recip_rd};
    end
  end

  lsvm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Score of the class in the scoring stage: accumulator plus intercept in Q32.32.
  logic signed [SW-1:0] score;
  logic signed [SW-1:0] score_acc;
  logic signed [SW-1:0] icpt_ext;

  assign score_acc = acc_valid[stag1] ? acc_rd : '0;
  assign icpt_ext  = {{(SW - VW - 16){icpt_rd[VW-1]}}, icpt_rd, 16'b0};
  assign score     = lsvm_pkg::sat_add(score_acc, icpt_ext);

  logic res_load;
  assign res_load = (state == S_RESULT) && !sv1 && (!m_valid || m_axis_tready);

  // Sequencer, pipelines and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pos        <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      sv1        <= 1'b0;
      acc_valid  <= '0;
      m_valid    <= 1'b0;
      active_cfg <= lsvm_pkg::ACTIVE_RESET;
    end else begin
      if (cfg_we) begin
        active_cfg <= cfg_wdata;
      end
      if (m_valid && m_axis_tready && !res_load) begin
        m_valid <= 1'b0;
      end

      // Accumulate pipeline advances every cycle.
      v1   <= (state == S_ACC);
      v2   <= v1;
      tag2 <= tag1;
      acc2 <= acc_valid[tag1] ? acc_rd : '0;
      if (v2) begin
        acc_valid[tag2] <= 1'b1;
      end

      // Scoring stage keeps the running best; the first class seeds it.
      sv1 <= (state == S_SCORE);
      if (sv1 && ((stag1 == '0) || (score > best))) begin
        best     <= score;
        best_idx <= stag1;
      end

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            s_val  <= val_in;
            s_last <= s_axis_tlast;
            if (op_in == lsvm_pkg::OP_SAMPLE) begin
              if (pos < POS_MAX) begin
                state <= S_NORM_MUL;
              end else if (s_axis_tlast) begin
                ci    <= '0;
                state <= S_SCORE;
              end
            end
          end
        end
        S_NORM_MUL: begin
          state <= S_NORM_SAT;
        end
        S_NORM_SAT: begin
          norm  <= round_sat(mul_p);
          waddr <= WAW'(pos);
          ci    <= '0;
          pos   <= pos + PW'(1);
          state <= S_ACC;
        end
        S_ACC: begin
          tag1  <= ci;
          ci    <= ci + CIW'(1);
          waddr <= waddr + ROW_STEP;
          if (ci == CLASS_LAST) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            if (s_last) begin
              ci    <= '0;
              state <= S_SCORE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SCORE: begin
          stag1 <= ci;
          ci    <= ci + CIW'(1);
          if (ci == n_last) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (res_load) begin
            m_valid   <= 1'b1;
            m_cls     <= lsvm_pkg::CLASS_W'(best_idx);
            m_score   <= best;
            acc_valid <= '0;
            pos       <= '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {4'b0, m_score, m_cls};

  // Checks on the sequencer.
  `LSVM_ASSERT_IMPLY(a_ready_empty, clk, rst, s_axis_tready, !v1 && !v2 && !sv1, "ready with work in flight")
  `LSVM_ASSERT_ALWAYS(a_pos_bound, clk, rst, pos <= POS_MAX, "feature position beyond count")
  `LSVM_ASSERT_IMPLY(a_acc_write, clk, rst, acc_we, (state == S_ACC) || (state == S_DRAIN), "accumulator written outside accumulation")
  `LSVM_ASSERT_IMPLY(a_class_range, clk, rst, m_valid, 32'(m_cls) < CLASS_COUNT, "predicted class out of range")
  `LSVM_ASSERT_NEXT(a_result_clear, clk, rst, res_load, (pos == '0) && (acc_valid == '0), "vector state not cleared after result")

endmodule
